// ===== hw/rtl/idc_pkg.sv =====
// Shared types, codes and constants of the ISA DMA controller.
// Used by idc_core and isa_dma_controller; depends on nothing else.
package idc_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W     = $clog2(CHANNELS);
    localparam int PAGE_W   = 4;
    localparam int WORD_W   = 16;
    localparam int ADDR_W   = PAGE_W + WORD_W;

    // Stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Operation codes carried in the input tuser
    typedef enum logic [2:0] {
        OP_PORT_WR       = 3'd0,
        OP_PORT_RD       = 3'd1,
        OP_PAGE_WR       = 3'd2,
        OP_PAGE_RD       = 3'd3,
        OP_XFER_FROM_MEM = 3'd4,
        OP_XFER_TO_MEM   = 3'd5
    } t_op;

    // Per-channel address direction
    typedef enum logic [1:0] {
        STEP_HOLD = 2'd0,
        STEP_INC  = 2'd1,
        STEP_DEC  = 2'd2
    } t_step;

    // Control port addresses above the channel register block
    localparam logic [3:0] PORT_STATUS     = 4'h8;
    localparam logic [3:0] PORT_MODE       = 4'hB;
    localparam logic [3:0] PORT_CLR_FF     = 4'hC;
    localparam logic [3:0] PORT_MASTER_CLR = 4'hD;

    // Page port addresses for channels 0..3
    localparam logic [3:0] PAGE_PORT_CH0 = 4'h7;
    localparam logic [3:0] PAGE_PORT_CH1 = 4'h3;
    localparam logic [3:0] PAGE_PORT_CH2 = 4'h1;
    localparam logic [3:0] PAGE_PORT_CH3 = 4'h2;

    localparam logic [7:0]        STATUS_BYTE   = 8'h0F;
    localparam logic [7:0]        UNMAPPED_BYTE = 8'hFF;
    localparam logic [WORD_W-1:0] COUNT_WRAP    = 16'hFFFF;

    typedef struct packed {
        t_op            operation;
        logic [3:0]     port;
        logic [7:0]     value;
        logic [CH_W-1:0] channel;
    } t_item;

    typedef struct packed {
        logic [7:0]        read_data;
        logic [ADDR_W-1:0] mem_address;
        logic              mem_read;
        logic              mem_write;
        logic [7:0]        mem_write_data;
    } t_result;

    typedef struct packed {
        logic            hit;
        logic [CH_W-1:0] ch;
    } t_page_map;

    // Page port to channel decode
    function automatic t_page_map page_channel(input logic [3:0] port);
        t_page_map m;
        m.hit = 1'b1;
        case (port)
            PAGE_PORT_CH0: m.ch = CH_W'(0);
            PAGE_PORT_CH1: m.ch = CH_W'(1);
            PAGE_PORT_CH2: m.ch = CH_W'(2);
            PAGE_PORT_CH3: m.ch = CH_W'(3);
            default: begin
                m.hit = 1'b0;
                m.ch  = '0;
            end
        endcase
        return m;
    endfunction

endpackage

// ===== hw/rtl/isa_dma_controller.sv =====
// Top level of the four-channel ISA DMA controller: input and result registers
// around idc_core. Depends on idc_pkg and idc_core.
//
//  channel  | dir | tdata                                   | tuser
//  ---------+-----+-----------------------------------------+--------------------
//  s_axis   | in  | port, value, channel                    | operation
//  m_axis   | out | read_data, mem_address, mem_write_data  | mem_read, mem_write
//
// One transfer in, one transfer out; one item per cycle while m_axis_tready is high.
// Path: input register, then decode and state update into the result register.
// The input register is free again in the cycle the core consumes it, so the
// block keeps taking items while a result waits, until both registers are full.
// i_rst_n (synchronous) clears all channel state, the flip-flop and both valids.
module isa_dma_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [3:0] port, [11:4] value, [13:12] channel, [15:14] zero
    input  logic [idc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] operation
    input  logic [idc_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] read_data, [27:8] mem_address, [35:28] mem_write_data, [39:36] zero
    output logic [idc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // [0] mem_read, [1] mem_write
    output logic [idc_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
    import idc_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    advance;

    // Core consumes the held item when the result register can take it
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.operation <= t_op'(s_axis_tuser);
            r_in.port      <= s_axis_tdata[3:0];
            r_in.value     <= s_axis_tdata[11:4];
            r_in.channel   <= s_axis_tdata[12 +: CH_W];
        end
    end

    idc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'h0, r_out.mem_write_data, r_out.mem_address, r_out.read_data};
    assign m_axis_tuser  = {r_out.mem_write, r_out.mem_read};

endmodule

// ===== hw/rtl/idc_core.sv =====
// Channel register file and single-pass decode of one bus access or transfer.
// Depends on idc_pkg.
module idc_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  idc_pkg::t_item  i_item,
    output idc_pkg::t_result o_result
);
    import idc_pkg::*;

    logic              r_flipflop, n_flipflop;
    logic [7:0]        r_pend_cnt_lo, n_pend_cnt_lo;
    logic [7:0]        r_pend_addr_lo, n_pend_addr_lo;
    logic [PAGE_W-1:0] r_page      [CHANNELS];
    logic [PAGE_W-1:0] n_page      [CHANNELS];
    logic [WORD_W-1:0] r_cur_addr  [CHANNELS];
    logic [WORD_W-1:0] n_cur_addr  [CHANNELS];
    logic [WORD_W-1:0] r_base_addr [CHANNELS];
    logic [WORD_W-1:0] n_base_addr [CHANNELS];
    logic [WORD_W-1:0] r_cur_cnt   [CHANNELS];
    logic [WORD_W-1:0] n_cur_cnt   [CHANNELS];
    logic [WORD_W-1:0] r_base_cnt  [CHANNELS];
    logic [WORD_W-1:0] n_base_cnt  [CHANNELS];
    logic              r_auto      [CHANNELS];
    logic              n_auto      [CHANNELS];
    t_step             r_step      [CHANNELS];
    t_step             n_step      [CHANNELS];

    t_page_map         page_map;
    logic              is_reg_port;
    logic [CH_W-1:0]   sel_ch;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] hi_word_cnt;
    logic [WORD_W-1:0] hi_word_addr;
    logic [WORD_W-1:0] x_addr_step;
    logic [WORD_W-1:0] x_cnt_dec;
    logic              x_reload;
    logic [WORD_W-1:0] x_addr_next;
    logic [WORD_W-1:0] x_cnt_next;
    logic [ADDR_W-1:0] x_mem_addr;

    // Channel select: one index per item
    assign page_map    = page_channel(i_item.port);
    assign is_reg_port = ~i_item.port[3];

    always_comb begin
        case (i_item.operation)
            OP_PORT_WR, OP_PORT_RD:
                sel_ch = is_reg_port ? i_item.port[2:1] : i_item.value[CH_W-1:0];
            OP_PAGE_WR, OP_PAGE_RD:
                sel_ch = page_map.ch;
            OP_XFER_FROM_MEM, OP_XFER_TO_MEM:
                sel_ch = i_item.channel;
            default:
                sel_ch = '0;
        endcase
    end

    // Register read and high-byte assembly
    assign rd_word      = i_item.port[0] ? r_cur_cnt[sel_ch] : r_cur_addr[sel_ch];
    assign hi_word_cnt  = {i_item.value, r_pend_cnt_lo};
    assign hi_word_addr = {i_item.value, r_pend_addr_lo};

    // Transfer: address step, count decrement, auto reload on wrap
    always_comb begin
        case (r_step[sel_ch])
            STEP_INC: x_addr_step = r_cur_addr[sel_ch] + WORD_W'(1);
            STEP_DEC: x_addr_step = r_cur_addr[sel_ch] - WORD_W'(1);
            default:  x_addr_step = r_cur_addr[sel_ch];
        endcase
    end

    assign x_cnt_dec   = r_cur_cnt[sel_ch] - WORD_W'(1);
    assign x_reload    = (x_cnt_dec == COUNT_WRAP) && r_auto[sel_ch];
    assign x_addr_next = x_reload ? r_base_addr[sel_ch] : x_addr_step;
    assign x_cnt_next  = x_reload ? r_base_cnt[sel_ch] : x_cnt_dec;
    assign x_mem_addr  = {r_page[sel_ch], r_cur_addr[sel_ch]};

    // Next state and result
    always_comb begin
        n_flipflop     = r_flipflop;
        n_pend_cnt_lo  = r_pend_cnt_lo;
        n_pend_addr_lo = r_pend_addr_lo;
        n_page         = r_page;
        n_cur_addr     = r_cur_addr;
        n_base_addr    = r_base_addr;
        n_cur_cnt      = r_cur_cnt;
        n_base_cnt     = r_base_cnt;
        n_auto         = r_auto;
        n_step         = r_step;
        o_result       = '0;

        case (i_item.operation)
            OP_PORT_WR: begin
                if (is_reg_port) begin
                    if (r_flipflop) begin
                        if (i_item.port[0]) begin
                            n_cur_cnt[sel_ch]  = hi_word_cnt;
                            n_base_cnt[sel_ch] = hi_word_cnt;
                        end else begin
                            n_cur_addr[sel_ch]  = hi_word_addr;
                            n_base_addr[sel_ch] = hi_word_addr;
                        end
                    end else if (i_item.port[0]) begin
                        n_pend_cnt_lo = i_item.value;
                    end else begin
                        n_pend_addr_lo = i_item.value;
                    end
                    n_flipflop = ~r_flipflop;
                end else begin
                    case (i_item.port)
                        PORT_MODE: begin
                            n_auto[sel_ch] = i_item.value[4];
                            n_step[sel_ch] = i_item.value[5] ? STEP_DEC : STEP_INC;
                        end
                        PORT_MASTER_CLR: begin
                            // Per-channel state to zero, pending low bytes kept
                            for (int c = 0; c < CHANNELS; c++) begin
                                n_page[c]      = '0;
                                n_cur_addr[c]  = '0;
                                n_base_addr[c] = '0;
                                n_cur_cnt[c]   = '0;
                                n_base_cnt[c]  = '0;
                                n_auto[c]      = 1'b0;
                                n_step[c]      = STEP_HOLD;
                            end
                            n_flipflop = 1'b0;
                        end
                        PORT_CLR_FF: n_flipflop = 1'b0;
                        default: ;
                    endcase
                end
            end
            OP_PORT_RD: begin
                if (is_reg_port) begin
                    o_result.read_data = r_flipflop ? rd_word[15:8] : rd_word[7:0];
                    n_flipflop         = ~r_flipflop;
                end else begin
                    o_result.read_data = (i_item.port == PORT_STATUS) ? STATUS_BYTE
                                                                      : UNMAPPED_BYTE;
                end
            end
            OP_PAGE_WR: begin
                if (page_map.hit) begin
                    n_page[sel_ch] = i_item.value[PAGE_W-1:0];
                end
            end
            OP_PAGE_RD: begin
                o_result.read_data = page_map.hit ? {4'h0, r_page[sel_ch]} : UNMAPPED_BYTE;
            end
            OP_XFER_FROM_MEM: begin
                o_result.mem_address = x_mem_addr;
                o_result.mem_read    = 1'b1;
                n_cur_addr[sel_ch]   = x_addr_next;
                n_cur_cnt[sel_ch]    = x_cnt_next;
            end
            OP_XFER_TO_MEM: begin
                o_result.mem_address    = x_mem_addr;
                o_result.mem_write      = 1'b1;
                o_result.mem_write_data = i_item.value;
                n_cur_addr[sel_ch]      = x_addr_next;
                n_cur_cnt[sel_ch]       = x_cnt_next;
            end
            default: ;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flipflop     <= 1'b0;
            r_pend_cnt_lo  <= '0;
            r_pend_addr_lo <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_page[c]      <= '0;
                r_cur_addr[c]  <= '0;
                r_base_addr[c] <= '0;
                r_cur_cnt[c]   <= '0;
                r_base_cnt[c]  <= '0;
                r_auto[c]      <= 1'b0;
                r_step[c]      <= STEP_HOLD;
            end
        end else if (i_fire) begin
            r_flipflop     <= n_flipflop;
            r_pend_cnt_lo  <= n_pend_cnt_lo;
            r_pend_addr_lo <= n_pend_addr_lo;
            r_page         <= n_page;
            r_cur_addr     <= n_cur_addr;
            r_base_addr    <= n_base_addr;
            r_cur_cnt      <= n_cur_cnt;
            r_base_cnt     <= n_base_cnt;
            r_auto         <= n_auto;
            r_step         <= n_step;
        end
    end

endmodule
